// File: src/weighted_hessian_window_macros.svh
// assertion macros shared by the checker
`ifndef WEIGHTED_HESSIAN_WINDOW_MACROS_SVH
`define WEIGHTED_HESSIAN_WINDOW_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define WHW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the block clock, off during reset
`define WHW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/whw_pkg.sv
package whw_pkg;

  // field widths
  localparam int PIX_W   = 16;
  localparam int CFG_W   = 11;
  localparam int OUT_W   = 19;
  localparam int COORD_W = 10;
  localparam int ROW_W   = 10;
  localparam int LINE_W  = 64;

  // window geometry
  localparam int WIN_N   = 5;
  localparam int WIN_MID = 2;

  // arithmetic widths
  localparam int DIFF_W = 18;
  localparam int GRP_W  = 20;
  localparam int WGT_W  = 17;
  localparam int PROD_W = 37;
  localparam int SUM_W  = 39;

  // gaussian weights, q0.16
  localparam logic signed [WGT_W-1:0] W_CORNER = 17'sd2943;
  localparam logic signed [WGT_W-1:0] W_EDGE   = 17'sd8002;
  localparam logic signed [WGT_W-1:0] W_CENTRE = 17'sd21751;

  // output scaling: second differences by 2^16, mixed term also by 4
  localparam int SH_DD  = 16;
  localparam int SH_DXY = 18;
  localparam logic signed [SUM_W-1:0] RND_DD  = SUM_W'(1 << (SH_DD - 1));
  localparam logic signed [SUM_W-1:0] RND_DXY = SUM_W'(1 << (SH_DXY - 1));

  // image width after reset
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  // sampled edges from an accepted pixel to its result first seen valid
  localparam int RESULT_LAG = 5;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [OUT_W-1:0]   neg_dxx;
    logic [OUT_W-1:0]   neg_dxy;
    logic [OUT_W-1:0]   neg_dyy;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } res_t;

endpackage

// File: src/weighted_hessian_window.sv
// a result is queued once the pixel that completes its window is accepted; one
// pixel per cycle while in_stall_o is low, set by one read-modify-write of the
// line store per pixel, with the previous write forwarded to the next read
// reset clears the counters, the 5x5 window, the result queue and sets the
// width to 640; the line store is not cleared and needs no sweep after reset
module weighted_hessian_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [whw_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [whw_pkg::PIX_W-1:0]   pixel_i,
  input  logic                               start_of_frame_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [whw_pkg::OUT_W-1:0]   neg_dxx_o,
  output logic signed [whw_pkg::OUT_W-1:0]   neg_dxy_o,
  output logic signed [whw_pkg::OUT_W-1:0]   neg_dyy_o,
  output logic [whw_pkg::COORD_W-1:0]        center_row_o,
  output logic [whw_pkg::COORD_W-1:0]        center_col_o
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CMP_W = (AW + 1 > whw_pkg::CFG_W) ? AW + 1 : whw_pkg::CFG_W;
  localparam int RES_W = whw_pkg::FIFO_AW + 2;

  // derivative axes and weight classes
  localparam int NUM_AX  = 3;
  localparam int AX_XX   = 0;
  localparam int AX_XY   = 1;
  localparam int AX_YY   = 2;
  localparam int NUM_CLS = 3;
  localparam logic [1:0] CLS_CRN = 2'd0;
  localparam logic [1:0] CLS_EDG = 2'd1;
  localparam logic [1:0] CLS_CTR = 2'd2;

  function automatic logic signed [whw_pkg::WGT_W-1:0] wgt(logic [1:0] c);
    logic signed [whw_pkg::WGT_W-1:0] w;
    unique case (c)
      CLS_CRN: w = whw_pkg::W_CORNER;
      CLS_EDG: w = whw_pkg::W_EDGE;
      default: w = whw_pkg::W_CENTRE;
    endcase
    return w;
  endfunction

  logic in_acc;
  logic pop;

  // width register
  logic [whw_pkg::CFG_W-1:0] image_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= whw_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      image_width_q <= cfg_wdata_i;
    end
  end

  // width clamped into one to MAX_WIDTH
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] eff_w;

  assign width_ext = CMP_W'(image_width_q);

  always_comb begin
    if (width_ext == '0) begin
      eff_w = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
  end

  // raster position of the incoming pixel and of the next one
  logic [AW-1:0]               col_q, col_d, col_a, col_b;
  logic [whw_pkg::ROW_W-1:0]   row_q, row_d, row_a, row_b;
  logic [CMP_W-1:0]            col_a_ext, col_b_ext, col_inc;
  logic                        emit_a;
  logic [whw_pkg::COORD_W-1:0] ctr_row_a, ctr_col_a;

  always_comb begin
    col_a     = start_of_frame_i ? '0 : col_q;
    row_a     = start_of_frame_i ? '0 : row_q;
    col_a_ext = CMP_W'(col_a);
    if (col_a_ext >= eff_w) begin
      col_b = '0;
      row_b = row_a + whw_pkg::ROW_W'(1);
    end else begin
      col_b = col_a;
      row_b = row_a;
    end
    col_b_ext = CMP_W'(col_b);
    emit_a    = (row_b >= whw_pkg::ROW_W'(whw_pkg::WIN_N - 1))
             && (col_b_ext >= CMP_W'(whw_pkg::WIN_N - 1));
    ctr_row_a = whw_pkg::COORD_W'(row_b - whw_pkg::ROW_W'(whw_pkg::WIN_MID));
    ctr_col_a = whw_pkg::COORD_W'(col_b_ext - CMP_W'(whw_pkg::WIN_MID));
    col_inc   = col_b_ext + CMP_W'(1);
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = row_b + whw_pkg::ROW_W'(1);
    end else begin
      col_d = col_inc[AW-1:0];
      row_d = row_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: pixel waits for its line store column
  logic                        s1_valid_q;
  logic                        s1_emit_q;
  logic                        s1_byp_q;
  whw_pkg::pix_t               s1_px_q;
  logic [AW-1:0]               s1_col_q;
  logic [whw_pkg::COORD_W-1:0] s1_row_c_q, s1_col_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q  <= emit_a;
      s1_byp_q   <= s1_valid_q && (s1_col_q == col_b);
      s1_px_q    <= pixel_i;
      s1_col_q   <= col_b;
      s1_row_c_q <= ctr_row_a;
      s1_col_c_q <= ctr_col_a;
    end
  end

  // line store: four earlier rows per column, newest in the low bits
  logic [whw_pkg::LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [whw_pkg::LINE_W-1:0] line_rd_q;
  logic [whw_pkg::LINE_W-1:0] line_last_q;
  logic [whw_pkg::LINE_W-1:0] line_old;
  logic [whw_pkg::LINE_W-1:0] line_wr;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= line_wr;
    end
    if (in_acc) begin
      line_rd_q <= line_mem[col_b];
    end
  end

  // forward the write of the previous beat when it hit the same column
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_last_q <= line_wr;
    end
  end

  assign line_old = s1_byp_q ? line_last_q : line_rd_q;
  assign line_wr  = {line_old[whw_pkg::LINE_W-whw_pkg::PIX_W-1:0], s1_px_q};

  // 5x5 window, shifted left by one column per pixel
  whw_pkg::pix_t win_q [whw_pkg::WIN_N][whw_pkg::WIN_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < whw_pkg::WIN_N; y++) begin
        for (int x = 0; x < whw_pkg::WIN_N; x++) begin
          win_q[y][x] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int y = 0; y < whw_pkg::WIN_N; y++) begin
        for (int x = 0; x < whw_pkg::WIN_N - 1; x++) begin
          win_q[y][x] <= win_q[y][x+1];
        end
      end
      for (int k = 0; k < whw_pkg::WIN_N - 1; k++) begin
        win_q[whw_pkg::WIN_N-2-k][whw_pkg::WIN_N-1] <=
          line_old[whw_pkg::PIX_W*k +: whw_pkg::PIX_W];
      end
      win_q[whw_pkg::WIN_N-1][whw_pkg::WIN_N-1] <= s1_px_q;
    end
  end

  // stage 2: window valid for an emitting centre
  logic                        s2_valid_q;
  logic [whw_pkg::COORD_W-1:0] s2_row_c_q, s2_col_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_row_c_q <= s1_row_c_q;
      s2_col_c_q <= s1_col_c_q;
    end
  end

  // second differences over the 3x3 centre, summed per weight class
  logic signed [whw_pkg::GRP_W-1:0] grp_d [NUM_AX][NUM_CLS];
  logic signed [whw_pkg::GRP_W-1:0] grp_q [NUM_AX][NUM_CLS];

  always_comb begin
    logic signed [whw_pkg::DIFF_W-1:0] dxx;
    logic signed [whw_pkg::DIFF_W-1:0] dyy;
    logic signed [whw_pkg::DIFF_W-1:0] dxy;
    logic [1:0]                        cls;
    for (int a = 0; a < NUM_AX; a++) begin
      for (int c = 0; c < NUM_CLS; c++) begin
        grp_d[a][c] = '0;
      end
    end
    for (int y = 1; y <= 3; y++) begin
      for (int x = 1; x <= 3; x++) begin
        dxx = whw_pkg::DIFF_W'(win_q[y][x+1]) + whw_pkg::DIFF_W'(win_q[y][x-1])
            - (whw_pkg::DIFF_W'(win_q[y][x]) <<< 1);
        dyy = whw_pkg::DIFF_W'(win_q[y+1][x]) + whw_pkg::DIFF_W'(win_q[y-1][x])
            - (whw_pkg::DIFF_W'(win_q[y][x]) <<< 1);
        dxy = whw_pkg::DIFF_W'(win_q[y+1][x+1]) - whw_pkg::DIFF_W'(win_q[y+1][x-1])
            - whw_pkg::DIFF_W'(win_q[y-1][x+1]) + whw_pkg::DIFF_W'(win_q[y-1][x-1]);
        if ((y != whw_pkg::WIN_MID) && (x != whw_pkg::WIN_MID)) begin
          cls = CLS_CRN;
        end else if ((y == whw_pkg::WIN_MID) && (x == whw_pkg::WIN_MID)) begin
          cls = CLS_CTR;
        end else begin
          cls = CLS_EDG;
        end
        grp_d[AX_XX][cls] = grp_d[AX_XX][cls] + whw_pkg::GRP_W'(dxx);
        grp_d[AX_XY][cls] = grp_d[AX_XY][cls] + whw_pkg::GRP_W'(dxy);
        grp_d[AX_YY][cls] = grp_d[AX_YY][cls] + whw_pkg::GRP_W'(dyy);
      end
    end
  end

  // stage 3: class sums registered
  logic                        s3_valid_q;
  logic [whw_pkg::COORD_W-1:0] s3_row_c_q, s3_col_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      grp_q      <= grp_d;
      s3_row_c_q <= s2_row_c_q;
      s3_col_c_q <= s2_col_c_q;
    end
  end

  // stage 4: one weight product per class and axis
  logic                             s4_valid_q;
  logic [whw_pkg::COORD_W-1:0]      s4_row_c_q, s4_col_c_q;
  logic signed [whw_pkg::PROD_W-1:0] prod_q [NUM_AX][NUM_CLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      for (int a = 0; a < NUM_AX; a++) begin
        for (int c = 0; c < NUM_CLS; c++) begin
          prod_q[a][c] <= whw_pkg::PROD_W'(grp_q[a][c]) * whw_pkg::PROD_W'(wgt(2'(c)));
        end
      end
      s4_row_c_q <= s3_row_c_q;
      s4_col_c_q <= s3_col_c_q;
    end
  end

  // sum, negate, round half up and scale back to q8.8
  logic signed [whw_pkg::SUM_W-1:0] acc [NUM_AX];
  logic signed [whw_pkg::SUM_W-1:0] sh_xx, sh_xy, sh_yy;
  whw_pkg::res_t                    res_d;

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      acc[a] = whw_pkg::SUM_W'(prod_q[a][CLS_CRN]) + whw_pkg::SUM_W'(prod_q[a][CLS_EDG])
             + whw_pkg::SUM_W'(prod_q[a][CLS_CTR]);
    end
    sh_xx = (whw_pkg::RND_DD - acc[AX_XX]) >>> whw_pkg::SH_DD;
    sh_xy = (whw_pkg::RND_DXY - acc[AX_XY]) >>> whw_pkg::SH_DXY;
    sh_yy = (whw_pkg::RND_DD - acc[AX_YY]) >>> whw_pkg::SH_DD;
    res_d.neg_dxx = sh_xx[whw_pkg::OUT_W-1:0];
    res_d.neg_dxy = sh_xy[whw_pkg::OUT_W-1:0];
    res_d.neg_dyy = sh_yy[whw_pkg::OUT_W-1:0];
    res_d.row     = s4_row_c_q;
    res_d.col     = s4_col_c_q;
  end

  // result queue; space is reserved for every beat still in flight
  whw_pkg::res_t                  fifo_mem [whw_pkg::FIFO_DEPTH];
  logic [whw_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [whw_pkg::FIFO_AW:0]      cnt_q;
  logic [RES_W-1:0]               reserved;

  always_ff @(posedge clk_i) begin
    if (s4_valid_q) begin
      fifo_mem[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s4_valid_q) begin
        wr_ptr_q <= wr_ptr_q + whw_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + whw_pkg::FIFO_AW'(1);
      end
      case ({s4_valid_q, pop})
        2'b10:   cnt_q <= cnt_q + (whw_pkg::FIFO_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (whw_pkg::FIFO_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign reserved = RES_W'(cnt_q) + RES_W'(s1_valid_q) + RES_W'(s2_valid_q)
                  + RES_W'(s3_valid_q) + RES_W'(s4_valid_q);

  // handshakes
  assign in_stall_o  = reserved >= RES_W'(whw_pkg::FIFO_DEPTH);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  assign neg_dxx_o    = fifo_mem[rd_ptr_q].neg_dxx;
  assign neg_dxy_o    = fifo_mem[rd_ptr_q].neg_dxy;
  assign neg_dyy_o    = fifo_mem[rd_ptr_q].neg_dyy;
  assign center_row_o = fifo_mem[rd_ptr_q].row;
  assign center_col_o = fifo_mem[rd_ptr_q].col;

endmodule

// File: src/whw_checker.sv
`include "weighted_hessian_window_macros.svh"

module whw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [whw_pkg::OUT_W-1:0] neg_dxx_o,
  input logic signed [whw_pkg::OUT_W-1:0] neg_dxy_o,
  input logic signed [whw_pkg::OUT_W-1:0] neg_dyy_o,
  input logic [whw_pkg::COORD_W-1:0]      center_row_o,
  input logic [whw_pkg::COORD_W-1:0]      center_col_o
);

  // a stalled result beat stays offered
  `WHW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result beat dropped while stalled")

  // and does not change under stall
  `WHW_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(neg_dxx_o) && $stable(neg_dxy_o) && $stable(neg_dyy_o) && $stable(center_row_o) && $stable(center_col_o), "stalled result beat changed")

  // every centre keeps a two-pixel margin from the top and left edges
  `WHW_ASSERT_NOW(a_margin, out_valid_o, (center_row_o >= whw_pkg::COORD_W'(whw_pkg::WIN_MID)) && (center_col_o >= whw_pkg::COORD_W'(whw_pkg::WIN_MID)), "result centre inside the border")

  // the queue only turns non-empty from a pixel accepted RESULT_LAG sampled edges earlier
  `WHW_ASSERT_NOW(a_latency, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, whw_pkg::RESULT_LAG), "result without a matching input beat")

  // with the result queue empty the input side never stalls
  `WHW_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o, "input stalled with an empty result queue")

endmodule

bind weighted_hessian_window whw_checker u_whw_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_W = 1024;
  localparam longint OUT_HI = (longint'(1) <<< (whw_pkg::OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (whw_pkg::OUT_W - 1));

  typedef enum {PIX_FULL, PIX_SMALL, PIX_RAIL, PIX_CHECKER, PIX_SPIKE} pix_mode_e;

  logic                             clk_i            = 1'b0;
  logic                             rst_ni           = 1'b0;
  logic                             cfg_we_i         = 1'b0;
  logic [whw_pkg::CFG_W-1:0]        cfg_wdata_i      = '0;
  logic                             in_valid_i       = 1'b0;
  logic                             in_stall_o;
  whw_pkg::pix_t                    pixel_i          = '0;
  logic                             start_of_frame_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i      = 1'b0;
  logic signed [whw_pkg::OUT_W-1:0] neg_dxx_o;
  logic signed [whw_pkg::OUT_W-1:0] neg_dxy_o;
  logic signed [whw_pkg::OUT_W-1:0] neg_dyy_o;
  logic [whw_pkg::COORD_W-1:0]      center_row_o;
  logic [whw_pkg::COORD_W-1:0]      center_col_o;

  // predicted state of the block
  logic [whw_pkg::LINE_W-1:0] line_mem [MAX_W];
  whw_pkg::pix_t              win [whw_pkg::WIN_N][whw_pkg::WIN_N];
  int                         col_cnt;
  int                         row_cnt;
  logic [whw_pkg::CFG_W-1:0]  width_reg;

  // expected hessians, oldest first
  whw_pkg::res_t hessian_q [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int n_errors      = 0;
  int n_pixels      = 0;
  int n_results     = 0;
  int n_cfg_writes  = 0;

  weighted_hessian_window #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .start_of_frame_i(start_of_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .neg_dxx_o       (neg_dxx_o),
    .neg_dxy_o       (neg_dxy_o),
    .neg_dyy_o       (neg_dyy_o),
    .center_row_o    (center_row_o),
    .center_col_o    (center_col_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  // negate, round half up to q8.8 and saturate
  function automatic logic [whw_pkg::OUT_W-1:0] to_q8_8(input longint acc, input int sh);
    longint r;
    r = (-acc + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > OUT_HI) r = OUT_HI;
    if (r < OUT_LO) r = OUT_LO;
    return r[whw_pkg::OUT_W-1:0];
  endfunction

  // advance the window by one pixel and queue the hessian it completes
  function automatic void hessian_step(input whw_pkg::pix_t px, input logic sof);
    int w;
    int edges;
    logic [whw_pkg::LINE_W-1:0] old;
    longint axx, axy, ayy, wt, c;
    whw_pkg::res_t res;
    w = eff_width();
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) % 1024;
    end
    // shift window left, new column from the line store and the pixel
    old = line_mem[col_cnt];
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 4; x++)
        win[y][x] = win[y][x + 1];
    for (int k = 0; k < 4; k++)
      win[3 - k][4] = old[16 * k +: 16];
    win[4][4] = px;
    line_mem[col_cnt] = {old[47:0], px};
    // weighted second differences over the 3x3 core
    if (row_cnt >= 4 && col_cnt >= 4) begin
      axx = 0;
      axy = 0;
      ayy = 0;
      for (int y = 1; y <= 3; y++) begin
        for (int x = 1; x <= 3; x++) begin
          edges = int'(y != 2) + int'(x != 2);
          wt = (edges == 2) ? longint'(whw_pkg::W_CORNER) :
               (edges == 1) ? longint'(whw_pkg::W_EDGE) : longint'(whw_pkg::W_CENTRE);
          c = win[y][x];
          axx += wt * (longint'(win[y][x + 1]) + win[y][x - 1] - 2 * c);
          ayy += wt * (longint'(win[y + 1][x]) + win[y - 1][x] - 2 * c);
          axy += wt * (longint'(win[y + 1][x + 1]) - win[y + 1][x - 1]
                       - win[y - 1][x + 1] + win[y - 1][x - 1]);
        end
      end
      res.neg_dxx = to_q8_8(axx, whw_pkg::SH_DD);
      res.neg_dxy = to_q8_8(axy, whw_pkg::SH_DXY);
      res.neg_dyy = to_q8_8(ayy, whw_pkg::SH_DD);
      res.row     = whw_pkg::COORD_W'(row_cnt - 2);
      res.col     = whw_pkg::COORD_W'(col_cnt - 2);
      hessian_q.push_back(res);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) % 1024;
    end
  endfunction

  function automatic void check_field(input string name, input logic [whw_pkg::OUT_W-1:0] want,
                                      input logic [whw_pkg::OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_errors++;
    end
  endfunction

  // result beats against the oldest expectation
  always @(posedge clk_i) begin : check_results
    whw_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hessian_q.size() == 0) begin
        $error("result beat at row %0d col %0d with nothing expected",
               center_row_o, center_col_o);
        n_errors++;
      end else begin
        want = hessian_q.pop_front();
        n_results++;
        check_field("neg_dxx", want.neg_dxx, neg_dxx_o);
        check_field("neg_dxy", want.neg_dxy, neg_dxy_o);
        check_field("neg_dyy", want.neg_dyy, neg_dyy_o);
        check_field("center_row", whw_pkg::OUT_W'(want.row), whw_pkg::OUT_W'(center_row_o));
        check_field("center_col", whw_pkg::OUT_W'(want.col), whw_pkg::OUT_W'(center_col_o));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic whw_pkg::pix_t make_pixel(input pix_mode_e mode, input int r, input int c);
    case (mode)
      PIX_FULL:    return whw_pkg::pix_t'($urandom);
      PIX_SMALL:   return whw_pkg::pix_t'($urandom_range(1023) - 512);
      PIX_RAIL:    return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      PIX_CHECKER: return ((r + c) % 2) ? 16'sh7FFF : 16'sh8000;
      PIX_SPIKE: begin
        if ($urandom_range(9) == 0) return whw_pkg::pix_t'($urandom);
        return whw_pkg::pix_t'($urandom_range(15) - 8);
      end
      default:     return '0;
    endcase
  endfunction

  // one pixel beat; entered and left at a falling edge, valid left high
  task automatic send_pixel(input whw_pkg::pix_t px, input logic sof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    pixel_i          <= px;
    start_of_frame_i <= sof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hessian_step(px, sof);
    n_pixels++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int rows, input int extra, input pix_mode_e mode,
                            input logic sof);
    int w;
    int total;
    w = eff_width();
    total = rows * w + extra;
    for (int i = 0; i < total; i++)
      send_pixel(make_pixel(mode, i / w, i % w), sof && (i == 0));
  endtask

  // block drained: all results in, pipeline settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (hessian_q.size() != 0) @(posedge clk_i);
    repeat (whw_pkg::RESULT_LAG + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_width(input logic [whw_pkg::CFG_W-1:0] w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    width_reg = w;
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // full-scale checkerboard and rail values
  task automatic test_rail_values();
    wait_idle();
    write_width(5);
    send_frame(6, 0, PIX_CHECKER, 1'b1);
    send_frame(5, 0, PIX_RAIL, 1'b1);
  endtask

  // widths below five never reach a centre column
  task automatic test_narrow_widths();
    wait_idle();
    write_width('0);
    send_frame(7, 0, PIX_FULL, 1'b1);
    wait_idle();
    write_width(4);
    send_frame(6, 0, PIX_FULL, 1'b1);
  endtask

  // shrink mid-row so the column sits past the new width
  task automatic test_column_past_width();
    wait_idle();
    write_width(12);
    send_frame(5, 9, PIX_SMALL, 1'b1);
    wait_idle();
    write_width(6);
    send_frame(5, 0, PIX_FULL, 1'b0);
  endtask

  // new frame started part way along a row
  task automatic test_frame_restart();
    wait_idle();
    write_width(7);
    send_frame(3, 4, PIX_FULL, 1'b1);
    send_frame(6, 2, PIX_SPIKE, 1'b1);
  endtask

  // random frames, widths and contents, some broken off or restarted mid-row;
  // a new width always opens a new frame so every column it uses gets filled
  task automatic test_random_frames(input int budget);
    int first;
    int pick;
    int rows;
    int extra;
    logic sof;
    logic [whw_pkg::CFG_W-1:0] w;
    first = n_pixels;
    while (n_pixels - first < budget) begin
      sof = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 60) begin
        wait_idle();
        pick = $urandom_range(99);
        if (pick < 70)      w = whw_pkg::CFG_W'($urandom_range(16, 5));
        else if (pick < 85) w = whw_pkg::CFG_W'($urandom_range(64, 17));
        else if (pick < 92) w = whw_pkg::CFG_W'($urandom_range(4, 0));
        else                w = whw_pkg::CFG_W'($urandom_range(120, 65));
        write_width(w);
        sof = 1'b1;
      end
      rows  = (eff_width() > 64) ? 5 : $urandom_range(8, 5);
      extra = ($urandom_range(99) < 25) ? $urandom_range(eff_width(), 0) : 0;
      send_frame(rows, extra, pix_mode_e'($urandom_range(4)), sof);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_W; i++) line_mem[i] = '0;
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 5; x++)
        win[y][x] = '0;
    col_cnt   = 0;
    row_cnt   = 0;
    width_reg = whw_pkg::WIDTH_RESET;

    // reset
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 19;
    stall_pct     = 75;
    test_rail_values();
    test_narrow_widths();
    test_column_past_width();
    test_frame_restart();

    send_idle_pct = 75;
    stall_pct     = 19;
    test_random_frames(300);

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_frames(300);

    // drain and watch for stray beats
    in_valid_i <= 1'b0;
    while (hessian_q.size() != 0) @(posedge clk_i);
    repeat (whw_pkg::RESULT_LAG * 4) @(posedge clk_i);
    if (hessian_q.size() != 0) begin
      $error("%0d expected results never arrived", hessian_q.size());
      n_errors++;
    end

    $display("tb_top: %0d pixels in, %0d hessians checked, %0d width writes, %0d errors",
             n_pixels, n_results, n_cfg_writes, n_errors);
    $display("tb_top: covered rail values, narrow widths, a width cut mid-row, restarts");
    $display("tb_top: and random frames under three sender and receiver idling mixes");
    if (n_errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
